/* src/dpsc_pkg.sv */
package dpsc_pkg;

	localparam logic [31:0] BATTERY_CHECK_INTERVAL_MS = 32'd30000;
	localparam logic [12:0] LEVEL_CHECK_CEILING_MV    = 13'd3600;

	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_ACTIVE = 3'd1;
	localparam logic [2:0] CMD_NIGHT  = 3'd2;
	localparam logic [2:0] CMD_IDLE   = 3'd3;
	localparam logic [2:0] CMD_OFF    = 3'd4;

	localparam logic [1:0] SLEEP_NONE  = 2'd0;
	localparam logic [1:0] SLEEP_NIGHT = 2'd1;
	localparam logic [1:0] SLEEP_IDLE  = 2'd2;

	localparam logic [2:0] REG_IDLE_DIM          = 3'd0;
	localparam logic [2:0] REG_NIGHT_DIM_DELAY   = 3'd1;
	localparam logic [2:0] REG_DARK_STANDBY      = 3'd2;
	localparam logic [2:0] REG_NIGHT_DEEP_SLEEP  = 3'd3;
	localparam logic [2:0] REG_IDLE_STANDBY      = 3'd4;
	localparam logic [2:0] REG_IDLE_DEEP_EXTRA   = 3'd5;
	localparam logic [2:0] REG_LOW_BATTERY_MV    = 3'd6;
	localparam logic [2:0] REG_CRITICAL_LEVEL    = 3'd7;

	typedef struct packed {
		logic [31:0] idle_dim_ms;
		logic [31:0] night_dim_delay_ms;
		logic [31:0] dark_standby_delay_ms;
		logic [31:0] night_deep_sleep_delay_ms;
		logic [31:0] idle_standby_delay_ms;
		logic [31:0] idle_deep_sleep_extra_ms;
		logic [12:0] low_battery_mv;
		logic [6:0]  critical_level_pct;
	} cfg_t;

	typedef struct packed {
		logic        idle_dimmed;
		logic        night_dimmed;
		logic        standby;
		logic        low_batt_latch;
		logic [31:0] last_check_ms;
		logic [31:0] dark_since_ms;
	} state_t;

	typedef struct packed {
		logic [31:0]       now_ms;
		logic              key_pressed;
		logic [31:0]       idle_for_ms;
		logic              screen_dark;
		logic [12:0]       battery_mv;
		logic signed [7:0] battery_level;
	} item_t;

	typedef struct packed {
		logic       woke;
		logic [2:0] brightness_cmd;
		logic [1:0] sleep_request;
		logic       save_request;
		logic       display_standby;
		logic       any_dimmed;
		logic       battery_low;
	} result_t;

endpackage

/* src/dpsc_cfg.sv */
module dpsc_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [2:0]     wr_index,
	input  logic [31:0]    wr_data,
	output dpsc_pkg::cfg_t cfg
);
	import dpsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_dim_ms               <= 32'd30000;
			cfg_q.night_dim_delay_ms        <= 32'd1200;
			cfg_q.dark_standby_delay_ms     <= 32'd60000;
			cfg_q.night_deep_sleep_delay_ms <= 32'd180000;
			cfg_q.idle_standby_delay_ms     <= 32'd600000;
			cfg_q.idle_deep_sleep_extra_ms  <= 32'd180000;
			cfg_q.low_battery_mv            <= 13'd3450;
			cfg_q.critical_level_pct        <= 7'd5;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IDLE_DIM:         cfg_q.idle_dim_ms               <= wr_data;
				REG_NIGHT_DIM_DELAY:  cfg_q.night_dim_delay_ms        <= wr_data;
				REG_DARK_STANDBY:     cfg_q.dark_standby_delay_ms     <= wr_data;
				REG_NIGHT_DEEP_SLEEP: cfg_q.night_deep_sleep_delay_ms <= wr_data;
				REG_IDLE_STANDBY:     cfg_q.idle_standby_delay_ms     <= wr_data;
				REG_IDLE_DEEP_EXTRA:  cfg_q.idle_deep_sleep_extra_ms  <= wr_data;
				REG_LOW_BATTERY_MV:   cfg_q.low_battery_mv            <= wr_data[12:0];
				REG_CRITICAL_LEVEL:   cfg_q.critical_level_pct        <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/dpsc_step.sv */
module dpsc_step (
	input  dpsc_pkg::cfg_t    cfg,
	input  dpsc_pkg::state_t  cur,
	input  dpsc_pkg::item_t   item,
	output dpsc_pkg::state_t  nxt,
	output dpsc_pkg::result_t res
);
	import dpsc_pkg::*;

	logic        check;
	logic        volt_low;
	logic        charge_low;
	logic        low;
	logic [31:0] dark_ref;
	logic [31:0] dark_age;
	logic [32:0] deep_idle_ms;
	state_t      s;
	logic        woke;
	logic [2:0]  cmd;
	logic [1:0]  sleep_req;
	logic        save;

	always_comb begin
		s         = cur;
		woke      = 1'b0;
		cmd       = CMD_NONE;
		sleep_req = SLEEP_NONE;

		check = (cur.last_check_ms == 32'd0) ||
			((item.now_ms - cur.last_check_ms) >= BATTERY_CHECK_INTERVAL_MS);
		volt_low  = (item.battery_mv != 13'd0) && (item.battery_mv < cfg.low_battery_mv);
		charge_low = !item.battery_level[7] &&
			(item.battery_level[6:0] <= cfg.critical_level_pct) &&
			(item.battery_mv != 13'd0) && (item.battery_mv < LEVEL_CHECK_CEILING_MV);
		low  = volt_low || charge_low;
		save = check && low && !cur.low_batt_latch;
		if (check) begin
			s.last_check_ms  = item.now_ms;
			s.low_batt_latch = low;
		end

		dark_ref     = (cur.dark_since_ms == 32'd0) ? item.now_ms : cur.dark_since_ms;
		dark_age     = item.now_ms - dark_ref;
		deep_idle_ms = {1'b0, cfg.idle_standby_delay_ms} +
			{1'b0, cfg.idle_deep_sleep_extra_ms};

		priority if (item.key_pressed) begin
			s.dark_since_ms = 32'd0;
			if (cur.idle_dimmed || cur.night_dimmed || cur.standby) begin
				s.idle_dimmed  = 1'b0;
				s.night_dimmed = 1'b0;
				s.standby      = 1'b0;
				woke           = 1'b1;
				cmd            = CMD_ACTIVE;
			end
		end else if (cur.standby) begin
			if (item.screen_dark && (cur.dark_since_ms != 32'd0) &&
				((item.now_ms - cur.dark_since_ms) >= cfg.night_deep_sleep_delay_ms)) begin
				sleep_req = SLEEP_NIGHT;
			end else if (!item.screen_dark && ({1'b0, item.idle_for_ms} >= deep_idle_ms)) begin
				sleep_req = SLEEP_IDLE;
			end
		end else if (item.screen_dark) begin
			s.dark_since_ms = dark_ref;
			if (!cur.night_dimmed && (dark_age >= cfg.night_dim_delay_ms)) begin
				s.idle_dimmed  = 1'b0;
				s.night_dimmed = 1'b1;
				cmd            = CMD_NIGHT;
			end
			if (dark_age >= cfg.dark_standby_delay_ms) begin
				s.standby      = 1'b1;
				s.idle_dimmed  = 1'b0;
				s.night_dimmed = 1'b0;
				cmd            = CMD_OFF;
			end
		end else begin
			s.dark_since_ms = 32'd0;
			if (cur.night_dimmed) begin
				s.idle_dimmed  = 1'b0;
				s.night_dimmed = 1'b0;
				cmd            = CMD_ACTIVE;
			end
			if (item.idle_for_ms >= cfg.idle_dim_ms) begin
				if (!s.idle_dimmed) begin
					s.idle_dimmed = 1'b1;
					cmd           = CMD_IDLE;
				end
				if (item.idle_for_ms >= cfg.idle_standby_delay_ms) begin
					s.standby      = 1'b1;
					s.idle_dimmed  = 1'b0;
					s.night_dimmed = 1'b0;
					cmd            = CMD_OFF;
				end
			end
		end

		res.woke            = woke;
		res.brightness_cmd  = cmd;
		res.sleep_request   = sleep_req;
		res.save_request    = save;
		res.display_standby = s.standby;
		res.any_dimmed      = s.idle_dimmed || s.night_dimmed || s.standby;
		res.battery_low     = s.low_batt_latch;
	end

	assign nxt = s;

endmodule

/* src/display_power_state_controller.sv */
// Display power state controller. Each input word is one update: it runs the
// periodic battery check, picks a brightness command and may request a deep
// sleep, giving exactly one result word. A word is registered on acceptance
// and its result is registered in the output stage when the word advances,
// and one word is taken every cycle while out_ready stays high; the rate is
// set by the state update that each word makes on the flags and timestamps
// before the next word uses them. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module display_power_state_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       now_ms,
	input  logic              key_pressed,
	input  logic [31:0]       idle_for_ms,
	input  logic              screen_dark,
	input  logic [12:0]       battery_mv,
	input  logic signed [7:0] battery_level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              woke,
	output logic [2:0]        brightness_cmd,
	output logic [1:0]        sleep_request,
	output logic              save_request,
	output logic              display_standby,
	output logic              any_dimmed,
	output logic              battery_low
);
	import dpsc_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign cfg_ready = 1'b1;

	dpsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dpsc_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.now_ms        <= now_ms;
			item_s1.key_pressed   <= key_pressed;
			item_s1.idle_for_ms   <= idle_for_ms;
			item_s1.screen_dark   <= screen_dark;
			item_s1.battery_mv    <= battery_mv;
			item_s1.battery_level <= battery_level;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign woke            = res_s2.woke;
	assign brightness_cmd  = res_s2.brightness_cmd;
	assign sleep_request   = res_s2.sleep_request;
	assign save_request    = res_s2.save_request;
	assign display_standby = res_s2.display_standby;
	assign any_dimmed      = res_s2.any_dimmed;
	assign battery_low     = res_s2.battery_low;

`ifndef SYNTHESIS
	a_save_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && save_request |-> battery_low)
		else $error("save request without low-battery latch");

	a_standby_dimmed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && display_standby |-> any_dimmed)
		else $error("standby not reported as dimmed");

	a_sleep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sleep_request != SLEEP_NONE) |->
			display_standby && !woke && (brightness_cmd == CMD_NONE))
		else $error("sleep request outside quiet standby");

	a_woke_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && woke |-> (brightness_cmd == CMD_ACTIVE) && !any_dimmed)
		else $error("wake without active command");
`endif

endmodule

/* bench/dpsc_checker.sv */
`timescale 1ns / 1ps

module dpsc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [31:0]       now_ms,
	input  logic              key_pressed,
	input  logic [31:0]       idle_for_ms,
	input  logic              screen_dark,
	input  logic [12:0]       battery_mv,
	input  logic signed [7:0] battery_level,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              woke,
	input  logic [2:0]        brightness_cmd,
	input  logic [1:0]        sleep_request,
	input  logic              save_request,
	input  logic              display_standby,
	input  logic              any_dimmed,
	input  logic              battery_low,
	output int                fail_count,
	output int                pending
);
	import dpsc_pkg::*;

	cfg_t        lim;
	logic        idle_dim_on;
	logic        night_dim_on;
	logic        standby_on;
	logic        batt_low;
	logic [31:0] batt_checked_ms;
	logic [31:0] dark_start_ms;
	result_t     expected_q[$];

	function automatic string fmt_result(input result_t r);
		return $sformatf("woke=%0d cmd=%0d sleep=%0d save=%0d standby=%0d dimmed=%0d low=%0d",
			r.woke, r.brightness_cmd, r.sleep_request, r.save_request,
			r.display_standby, r.any_dimmed, r.battery_low);
	endfunction

	task automatic apply_limit(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			REG_IDLE_DIM:         lim.idle_dim_ms = data;
			REG_NIGHT_DIM_DELAY:  lim.night_dim_delay_ms = data;
			REG_DARK_STANDBY:     lim.dark_standby_delay_ms = data;
			REG_NIGHT_DEEP_SLEEP: lim.night_deep_sleep_delay_ms = data;
			REG_IDLE_STANDBY:     lim.idle_standby_delay_ms = data;
			REG_IDLE_DEEP_EXTRA:  lim.idle_deep_sleep_extra_ms = data;
			REG_LOW_BATTERY_MV:   lim.low_battery_mv = data[12:0];
			REG_CRITICAL_LEVEL:   lim.critical_level_pct = data[6:0];
			default: ;
		endcase
	endtask

	task automatic enter_standby(inout logic [2:0] cmd);
		if (!standby_on) begin
			standby_on = 1'b1;
			idle_dim_on = 1'b0;
			night_dim_on = 1'b0;
			cmd = CMD_OFF;
		end
	endtask

	task automatic update_power_state(input item_t it, output result_t res);
		logic [31:0] dark_for;
		logic [32:0] idle_sleep_mark;
		logic        volt_low;
		logic        charge_low;
		logic        low;
		logic [2:0]  cmd;

		res = '0;
		cmd = CMD_NONE;
		res.sleep_request = SLEEP_NONE;

		if (batt_checked_ms == 32'd0 ||
		    it.now_ms - batt_checked_ms >= BATTERY_CHECK_INTERVAL_MS) begin
			batt_checked_ms = it.now_ms;
			volt_low = it.battery_mv != 13'd0 && it.battery_mv < lim.low_battery_mv;
			charge_low = !it.battery_level[7] &&
				it.battery_level[6:0] <= lim.critical_level_pct &&
				it.battery_mv != 13'd0 && it.battery_mv < LEVEL_CHECK_CEILING_MV;
			low = volt_low || charge_low;
			if (low && !batt_low) begin
				batt_low = 1'b1;
				res.save_request = 1'b1;
			end else if (!low) begin
				batt_low = 1'b0;
			end
		end

		if (it.key_pressed) begin
			dark_start_ms = 32'd0;
			if (idle_dim_on || night_dim_on || standby_on) begin
				idle_dim_on = 1'b0;
				night_dim_on = 1'b0;
				standby_on = 1'b0;
				res.woke = 1'b1;
				cmd = CMD_ACTIVE;
			end
		end else if (standby_on) begin
			dark_for = it.now_ms - dark_start_ms;
			idle_sleep_mark = {1'b0, lim.idle_standby_delay_ms} +
				{1'b0, lim.idle_deep_sleep_extra_ms};
			if (it.screen_dark && dark_start_ms != 32'd0 &&
			    dark_for >= lim.night_deep_sleep_delay_ms)
				res.sleep_request = SLEEP_NIGHT;
			else if (!it.screen_dark && {1'b0, it.idle_for_ms} >= idle_sleep_mark)
				res.sleep_request = SLEEP_IDLE;
		end else if (it.screen_dark) begin
			if (dark_start_ms == 32'd0)
				dark_start_ms = it.now_ms;
			dark_for = it.now_ms - dark_start_ms;
			if (!night_dim_on && dark_for >= lim.night_dim_delay_ms) begin
				idle_dim_on = 1'b0;
				night_dim_on = 1'b1;
				cmd = CMD_NIGHT;
			end
			if (dark_for >= lim.dark_standby_delay_ms)
				enter_standby(cmd);
		end else begin
			dark_start_ms = 32'd0;
			if (night_dim_on) begin
				idle_dim_on = 1'b0;
				night_dim_on = 1'b0;
				standby_on = 1'b0;
				cmd = CMD_ACTIVE;
			end
			if (it.idle_for_ms >= lim.idle_dim_ms) begin
				if (!idle_dim_on) begin
					idle_dim_on = 1'b1;
					cmd = CMD_IDLE;
				end
				if (it.idle_for_ms >= lim.idle_standby_delay_ms)
					enter_standby(cmd);
			end
		end

		res.brightness_cmd = cmd;
		res.display_standby = standby_on;
		res.any_dimmed = idle_dim_on || night_dim_on || standby_on;
		res.battery_low = batt_low;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			lim.idle_dim_ms = 32'd30000;
			lim.night_dim_delay_ms = 32'd1200;
			lim.dark_standby_delay_ms = 32'd60000;
			lim.night_deep_sleep_delay_ms = 32'd180000;
			lim.idle_standby_delay_ms = 32'd600000;
			lim.idle_deep_sleep_extra_ms = 32'd180000;
			lim.low_battery_mv = 13'd3450;
			lim.critical_level_pct = 7'd5;
			idle_dim_on = 1'b0;
			night_dim_on = 1'b0;
			standby_on = 1'b0;
			batt_low = 1'b0;
			batt_checked_ms = 32'd0;
			dark_start_ms = 32'd0;
			expected_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_limit(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				update_power_state({now_ms, key_pressed, idle_for_ms, screen_dark,
					battery_mv, battery_level}, want);
				expected_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = {woke, brightness_cmd, sleep_request, save_request,
					display_standby, any_dimmed, battery_low};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: %s", fmt_result(got));
				end else begin
					want = expected_q.pop_front();
					if (got.woke !== want.woke ||
					    got.brightness_cmd !== want.brightness_cmd ||
					    got.sleep_request !== want.sleep_request ||
					    got.save_request !== want.save_request ||
					    got.display_standby !== want.display_standby ||
					    got.any_dimmed !== want.any_dimmed ||
					    got.battery_low !== want.battery_low) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %s, got %s",
								fmt_result(want), fmt_result(got));
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

/* bench/tb_display_power_state_controller.sv */
`timescale 1ns / 1ps

module tb_display_power_state_controller;
	import dpsc_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 400;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [31:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [31:0]       now_ms;
	logic              key_pressed;
	logic [31:0]       idle_for_ms;
	logic              screen_dark;
	logic [12:0]       battery_mv;
	logic signed [7:0] battery_level;
	logic              out_valid;
	logic              out_ready;
	logic              woke;
	logic [2:0]        brightness_cmd;
	logic [1:0]        sleep_request;
	logic              save_request;
	logic              display_standby;
	logic              any_dimmed;
	logic              battery_low;
	int                fail_count;
	int                pending;

	int          send_gap_pct = 16;
	int          recv_gap_pct = 68;
	bit          hold_armed = 1'b0;
	bit          timed_out = 1'b0;
	logic [31:0] clock_ms;
	logic [31:0] idle_run_ms;
	logic        dark_run;
	logic [31:0] idle_marks[3];
	logic [12:0] mv_mark;

	display_power_state_controller dut (.*);

	dpsc_checker chk (.*);

	always #10 clk = ~clk;

	initial begin
		int left;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				for (left = HOLD_CYCLES; left > 0; left--) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	task automatic send_update(input logic [31:0] t, input logic press, input logic [31:0] idle,
			input logic dark, input logic [12:0] mv, input logic signed [7:0] lvl);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		key_pressed <= press;
		idle_for_ms <= idle;
		screen_dark <= dark;
		battery_mv <= mv;
		battery_level <= lvl;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [31:0] idle_dim, input logic [31:0] night_dim,
			input logic [31:0] dark_off, input logic [31:0] night_sleep,
			input logic [31:0] idle_off, input logic [31:0] idle_extra,
			input logic [12:0] low_mv, input logic [6:0] crit);
		settle();
		write_reg(REG_IDLE_DIM, idle_dim);
		write_reg(REG_NIGHT_DIM_DELAY, night_dim);
		write_reg(REG_DARK_STANDBY, dark_off);
		write_reg(REG_NIGHT_DEEP_SLEEP, night_sleep);
		write_reg(REG_IDLE_STANDBY, idle_off);
		write_reg(REG_IDLE_DEEP_EXTRA, idle_extra);
		write_reg(REG_LOW_BATTERY_MV, {19'd0, low_mv});
		write_reg(REG_CRITICAL_LEVEL, {25'd0, crit});
		idle_marks[0] = idle_dim;
		idle_marks[1] = idle_off;
		idle_marks[2] = idle_off + idle_extra;
		mv_mark = low_mv;
	endtask

	task automatic random_updates(input int count, input int scale, input int hold_at,
			input int pause_at);
		logic [31:0]       advance;
		logic [31:0]       idle;
		logic              press;
		logic [12:0]       mv;
		logic signed [7:0] lvl;
		int                r;
		clock_ms = $urandom;
		idle_run_ms = 32'd0;
		dark_run = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_armed = 1'b1;
			if (n == pause_at) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			r = $urandom_range(99);
			if (r < 70)
				advance = $urandom_range(scale);
			else if (r < 90)
				advance = $urandom_range(scale * 20);
			else if (r < 97)
				advance = $urandom;
			else
				advance = 32'd0;
			clock_ms += advance;
			idle_run_ms += advance;
			r = $urandom_range(199);
			if (r == 0)
				clock_ms = 32'd0;
			else if (r == 1)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(scale);
			press = ($urandom_range(99) < 5);
			if (press)
				idle_run_ms = 32'd0;
			if ($urandom_range(99) < 7)
				dark_run = ~dark_run;
			r = $urandom_range(99);
			if (r < 80)
				idle = idle_run_ms;
			else if (r < 95)
				idle = idle_marks[$urandom_range(2)] + 32'($urandom_range(2)) - 32'd1;
			else
				idle = $urandom;
			r = $urandom_range(99);
			if (r < 60)
				mv = 13'($urandom_range(3800, 3000));
			else if (r < 75)
				mv = 13'd0;
			else if (r < 85)
				mv = mv_mark + 13'($urandom_range(2)) - 13'd1;
			else
				mv = 13'($urandom_range(8191));
			r = $urandom_range(99);
			if (r < 50)
				lvl = 8'($urandom_range(10));
			else if (r < 65)
				lvl = -8'sd1;
			else if (r < 75)
				lvl = 8'sd100;
			else
				lvl = 8'($urandom);
			send_update(clock_ms, press, idle, dark_run, mv, lvl);
		end
	endtask

	task automatic directed_updates();
		send_update(32'd0, 1'b0, 32'd0, 1'b0, 13'd3000, 8'sd50);
		send_update(32'd5, 1'b0, 32'd0, 1'b0, 13'd4000, 8'sd50);
		send_update(32'd0, 1'b0, 32'd0, 1'b1, 13'd3500, 8'sd3);
		send_update(32'd100, 1'b0, 32'd0, 1'b1, 13'd8191, -8'sd1);
		send_update(32'd1300, 1'b0, 32'd0, 1'b1, 13'd0, 8'h80);
		send_update(32'd1400, 1'b1, 32'd0, 1'b1, 13'd3500, 8'sd5);
		send_update(32'd1500, 1'b1, 32'd0, 1'b0, 13'd3500, 8'sd6);
		send_update(32'd2000, 1'b0, 32'd0, 1'b1, 13'd3500, 8'sd0);
		send_update(32'd3200, 1'b0, 32'd0, 1'b1, 13'd3500, 8'sd0);
		send_update(32'd62000, 1'b0, 32'd0, 1'b1, 13'd3000, 8'sd127);
		send_update(32'd200000, 1'b0, 32'd0, 1'b1, 13'd3599, 8'sd4);
		send_update(32'd200100, 1'b0, 32'd780000, 1'b0, 13'd3600, 8'sd4);
		send_update(32'd200200, 1'b0, 32'd779999, 1'b0, 13'd3449, 8'sd100);
		send_update(32'd200300, 1'b1, 32'd0, 1'b0, 13'd3450, 8'sd100);
		send_update(32'd300000, 1'b0, 32'd30000, 1'b0, 13'd3451, 8'sd50);
		send_update(32'd300010, 1'b0, 32'd30010, 1'b1, 13'd3451, 8'sd50);
		send_update(32'd301210, 1'b0, 32'd31210, 1'b1, 13'd3451, 8'sd50);
		send_update(32'd301300, 1'b0, 32'd40000, 1'b0, 13'd3451, 8'sd50);
		send_update(32'd301400, 1'b1, 32'd0, 1'b0, 13'd3451, 8'sd50);
		send_update(32'd301500, 1'b0, 32'd600000, 1'b0, 13'd3451, 8'sd50);
		send_update(32'd301600, 1'b1, 32'd0, 1'b0, 13'd3451, 8'sd50);
		send_update(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 13'd8191, 8'sd127);
		send_update(32'hFFFF_FF00, 1'b1, 32'd0, 1'b1, 13'd1, 8'h80);
		send_update(32'hFFFF_FF80, 1'b0, 32'd0, 1'b1, 13'd1, 8'h80);
		send_update(32'd1200, 1'b0, 32'd0, 1'b1, 13'd1, 8'h80);
	endtask

	task automatic run_all();
		idle_marks[0] = 32'd30000;
		idle_marks[1] = 32'd600000;
		idle_marks[2] = 32'd780000;
		mv_mark = 13'd3450;
		directed_updates();
		random_updates(340, 20000, 100, -1);
		set_limits(32'd100, 32'd50, 32'd300, 32'd500, 32'd400, 32'd200, 13'd3450, 7'd5);
		random_updates(340, 150, -1, -1);

		send_gap_pct = 68;
		recv_gap_pct = 16;
		set_limits(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 13'd0, 7'd0);
		random_updates(330, 50, -1, -1);
		set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF, 7'd100);
		random_updates(330, 20000, -1, 150);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_limits($urandom_range(300), $urandom_range(100), $urandom_range(600),
			$urandom_range(900), 32'hFFFF_0000, 32'h0001_0000, 13'd3600, 7'd10);
		random_updates(330, 200, -1, -1);
		set_limits($urandom_range(500), $urandom_range(200), $urandom_range(800),
			$urandom_range(1200), $urandom_range(700), $urandom_range(400),
			13'($urandom), 7'($urandom_range(100)));
		random_updates(330, 120, -1, 160);
		settle();
	endtask

	task automatic watch_for_stall();
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		timed_out = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IDLE_DIM;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		now_ms = 32'd0;
		key_pressed = 1'b0;
		idle_for_ms = 32'd0;
		screen_dark = 1'b0;
		battery_mv = 13'd0;
		battery_level = 8'sd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		fork
			run_all();
			watch_for_stall();
		join_any
		if (!timed_out && fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
